>>> design/software_timer_table_core_macros.svh
// Assertion macros for the software timer table core.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef SOFTWARE_TIMER_TABLE_CORE_MACROS_SVH
`define SOFTWARE_TIMER_TABLE_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define STT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define STT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> design/stt_pkg.sv
// Shared constants, types and helper functions of the software timer table.
// No dependencies; stt_out and the top level refer to it by scoped names.
`default_nettype none

package stt_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int IDENT_BITS  = 16;

    localparam int SLOT_BITS   = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_BITS    = $clog2(TIMER_SLOTS + 1);
    localparam int DUR_BITS    = 31;
    localparam int ELAPSED_BITS = 32;
    localparam int OUT_ID_BITS = 16;
    localparam int CMP_BITS    = (IDENT_BITS > OUT_ID_BITS) ? IDENT_BITS : OUT_ID_BITS;

    localparam logic [CNT_BITS-1:0] SLOT_COUNT = CNT_BITS'(TIMER_SLOTS);

    localparam logic [1:0] CMD_SCHEDULE = 2'd0;
    localparam logic [1:0] CMD_CLEAR    = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;

    localparam logic [1:0] KIND_SCHED = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_FIRED = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    // One slot as held in the slot memory.
    typedef struct packed {
        logic                  periodic;
        logic [IDENT_BITS-1:0] ident;
        logic [DUR_BITS-1:0]   period;
        logic [DUR_BITS-1:0]   remaining;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef struct packed {
        logic [1:0]             kind;
        logic [OUT_ID_BITS-1:0] ident;
        logic [1:0]             status;
        logic                   last;
    } result_t;

    // Low output bits of an id, zero-extended when ids are narrow.
    function automatic logic [OUT_ID_BITS-1:0] ident_out(input logic [IDENT_BITS-1:0] id);
        logic [CMP_BITS-1:0] wide;
        wide = CMP_BITS'(id);
        return wide[OUT_ID_BITS-1:0];
    endfunction

    // Full-width compare of a stored id against a requested id.
    function automatic logic ident_match(input logic [IDENT_BITS-1:0] id,
                                         input logic [OUT_ID_BITS-1:0] target);
        return CMP_BITS'(id) == CMP_BITS'(target);
    endfunction

endpackage

`default_nettype wire

>>> design/stt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [ABITS-1:0] waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [ABITS-1:0] raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds when no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/stt_out.sv
// Output register of the software timer table: one result held until taken.
// Depends on stt_pkg for the result type.
`default_nettype none

module stt_out (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire stt_pkg::result_t res,
    input  wire logic             stall,
    output logic                  free,
    output logic                  valid,
    output stt_pkg::result_t      res_out
);

    logic             valid_reg;
    logic             valid_next;
    stt_pkg::result_t res_reg;

    // The register can take a new result when empty or when it drains this cycle.
    assign free = !valid_reg || !stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (!stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= res;
        end
    end

    assign valid   = valid_reg;
    assign res_out = res_reg;

endmodule

`default_nettype wire

>>> design/software_timer_table_core.sv
// Top level of the software timer table: control sequencer, slot flags and ids.
// Depends on stt_pkg, stt_ram, stt_out and software_timer_table_core_macros.svh.
//
// Usage: one request channel (in_valid/in_stall) carries schedule, clear and
// tick requests; one result channel (out_valid/out_stall) returns the results.
// A request is taken only when the block is idle. A schedule returns one
// answer. A clear walks the slot memory in index order and stops at the
// first match, with one answer. A tick with elapsed >= 0 walks all slots,
// one slot per cycle through the single read port of the slot memory,
// emitting a fired result for each expiring slot and then a tick done
// result. A tick with negative elapsed returns tick done without a walk.
// The final result of each request carries last = 1. Results pass through
// a one-entry output register; when the receiver stalls and that register
// is full, the walk holds in place and resumes when the register drains.
// Reset empties all slots and restarts ids at zero; the slot memory needs
// no clearing pass since entries are only used for slots marked in use.
`default_nettype none

`include "software_timer_table_core_macros.svh"

module software_timer_table_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [1:0]                          command,
    input  wire logic [stt_pkg::DUR_BITS-1:0]        duration,
    input  wire logic                                repeat_mode,
    input  wire logic [stt_pkg::OUT_ID_BITS-1:0]     target_id,
    input  wire logic signed [stt_pkg::ELAPSED_BITS-1:0] elapsed,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [1:0]                               kind,
    output logic [stt_pkg::OUT_ID_BITS-1:0]          timer_ident,
    output logic [1:0]                               status,
    output logic                                     last
);

    localparam int NS = stt_pkg::TIMER_SLOTS;
    localparam int SB = stt_pkg::SLOT_BITS;
    localparam int DB = stt_pkg::DUR_BITS;

    stt_pkg::state_t state_reg, state_next;
    logic [stt_pkg::CNT_BITS-1:0]   rd_idx_reg, rd_idx_next;
    logic                           proc_valid_reg, proc_valid_next;
    logic [SB-1:0]                  proc_idx_reg, proc_idx_next;
    logic                           is_tick_reg, is_tick_next;
    logic [NS-1:0]                  slot_used_reg, slot_used_next;
    logic [NS-1:0]                  slot_cleared_reg, slot_cleared_next;
    logic [stt_pkg::IDENT_BITS-1:0] next_ident_reg, next_ident_next;

    logic [DB-1:0]                  elapsed_reg, elapsed_next;
    logic [stt_pkg::OUT_ID_BITS-1:0] target_reg, target_next;
    logic [1:0]                     pend_kind_reg, pend_kind_next;
    logic [stt_pkg::OUT_ID_BITS-1:0] pend_ident_reg, pend_ident_next;
    logic [1:0]                     pend_status_reg, pend_status_next;

    logic                           ram_we;
    logic [SB-1:0]                  ram_waddr;
    stt_pkg::entry_t                ram_wdata;
    logic                           ram_re;
    logic [SB-1:0]                  ram_raddr;
    logic [stt_pkg::ENTRY_BITS-1:0] ram_rdata;
    stt_pkg::entry_t                rd_entry;

    logic                           out_push;
    logic                           out_free;
    stt_pkg::result_t               out_res;
    stt_pkg::result_t               out_q;

    logic                           free_found;
    logic [SB-1:0]                  free_idx;
    logic signed [DB:0]             diff;
    logic                           fire;
    logic                           live;
    logic                           hold;
    logic                           stop_walk;
    stt_pkg::entry_t                sched_entry;
    stt_pkg::entry_t                wb_entry;

    stt_ram #(
        .WIDTH(stt_pkg::ENTRY_BITS),
        .DEPTH(NS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    stt_out u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (out_push),
        .res    (out_res),
        .stall  (out_stall),
        .free   (out_free),
        .valid  (out_valid),
        .res_out(out_q)
    );

    assign kind        = out_q.kind;
    assign timer_ident = out_q.ident;
    assign status      = out_q.status;
    assign last        = out_q.last;

    assign rd_entry = stt_pkg::entry_t'(ram_rdata);

    // Lowest free slot for a schedule request.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NS - 1; i >= 0; i--)
        begin
            if (!slot_used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SB'(i);
            end
        end
    end

    // Both operands are 31-bit unsigned values, so 32 signed bits hold the step.
    assign diff = $signed({1'b0, rd_entry.remaining}) - $signed({1'b0, elapsed_reg});
    assign fire = diff[DB] || (diff == '0);
    assign live = slot_used_reg[proc_idx_reg] && !slot_cleared_reg[proc_idx_reg];
    assign hold = proc_valid_reg && is_tick_reg && live && fire && !out_free;

    always_comb
    begin
        sched_entry.periodic  = repeat_mode;
        sched_entry.ident     = next_ident_reg;
        sched_entry.period    = duration;
        sched_entry.remaining = duration;

        wb_entry = rd_entry;
        if (fire)
        begin
            wb_entry.remaining = rd_entry.period;
        end
        else
        begin
            wb_entry.remaining = diff[DB-1:0];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        rd_idx_next       = rd_idx_reg;
        proc_valid_next   = proc_valid_reg;
        proc_idx_next     = proc_idx_reg;
        is_tick_next      = is_tick_reg;
        slot_used_next    = slot_used_reg;
        slot_cleared_next = slot_cleared_reg;
        next_ident_next   = next_ident_reg;
        elapsed_next      = elapsed_reg;
        target_next       = target_reg;
        pend_kind_next    = pend_kind_reg;
        pend_ident_next   = pend_ident_reg;
        pend_status_next  = pend_status_reg;
        ram_we            = 1'b0;
        ram_waddr         = proc_idx_reg;
        ram_wdata         = wb_entry;
        ram_re            = 1'b0;
        ram_raddr         = rd_idx_reg[SB-1:0];
        out_push          = 1'b0;
        out_res           = '0;
        in_stall          = 1'b1;
        stop_walk         = 1'b0;

        case (state_reg)
            stt_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    case (command)
                        stt_pkg::CMD_SCHEDULE:
                        begin
                            pend_kind_next = stt_pkg::KIND_SCHED;
                            if (free_found)
                            begin
                                ram_we                      = 1'b1;
                                ram_waddr                   = free_idx;
                                ram_wdata                   = sched_entry;
                                slot_used_next[free_idx]    = 1'b1;
                                slot_cleared_next[free_idx] = 1'b0;
                                pend_ident_next  = stt_pkg::ident_out(next_ident_reg);
                                pend_status_next = stt_pkg::ST_OK;
                                next_ident_next  = next_ident_reg + 1'b1;
                            end
                            else
                            begin
                                pend_ident_next  = '0;
                                pend_status_next = stt_pkg::ST_FULL;
                            end
                            state_next = stt_pkg::S_DONE;
                        end
                        stt_pkg::CMD_CLEAR:
                        begin
                            pend_kind_next   = stt_pkg::KIND_CLEAR;
                            pend_ident_next  = target_id;
                            pend_status_next = stt_pkg::ST_NOTFOUND;
                            target_next      = target_id;
                            is_tick_next     = 1'b0;
                            rd_idx_next      = '0;
                            proc_valid_next  = 1'b0;
                            state_next       = stt_pkg::S_WALK;
                        end
                        stt_pkg::CMD_TICK:
                        begin
                            pend_kind_next   = stt_pkg::KIND_DONE;
                            pend_ident_next  = '0;
                            pend_status_next = stt_pkg::ST_OK;
                            if (elapsed[stt_pkg::ELAPSED_BITS-1])
                            begin
                                state_next = stt_pkg::S_DONE;
                            end
                            else
                            begin
                                elapsed_next    = elapsed[DB-1:0];
                                is_tick_next    = 1'b1;
                                rd_idx_next     = '0;
                                proc_valid_next = 1'b0;
                                state_next      = stt_pkg::S_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            stt_pkg::S_WALK:
            begin
                // The slot held in the RAM's read data register is processed while the next one is read.
                if (!hold)
                begin
                    if (proc_valid_reg && slot_used_reg[proc_idx_reg])
                    begin
                        if (is_tick_reg)
                        begin
                            if (slot_cleared_reg[proc_idx_reg])
                            begin
                                slot_used_next[proc_idx_reg]    = 1'b0;
                                slot_cleared_next[proc_idx_reg] = 1'b0;
                            end
                            else if (fire)
                            begin
                                out_push       = 1'b1;
                                out_res.kind   = stt_pkg::KIND_FIRED;
                                out_res.ident  = stt_pkg::ident_out(rd_entry.ident);
                                out_res.status = stt_pkg::ST_OK;
                                out_res.last   = 1'b0;
                                if (rd_entry.periodic)
                                begin
                                    ram_we = 1'b1;
                                end
                                else
                                begin
                                    slot_cleared_next[proc_idx_reg] = 1'b1;
                                end
                            end
                            else
                            begin
                                ram_we = 1'b1;
                            end
                        end
                        else if (stt_pkg::ident_match(rd_entry.ident, target_reg))
                        begin
                            slot_cleared_next[proc_idx_reg] = 1'b1;
                            pend_status_next = stt_pkg::ST_OK;
                            state_next       = stt_pkg::S_DONE;
                            proc_valid_next  = 1'b0;
                            stop_walk        = 1'b1;
                        end
                    end

                    if (!stop_walk)
                    begin
                        if (rd_idx_reg != stt_pkg::SLOT_COUNT)
                        begin
                            ram_re          = 1'b1;
                            proc_valid_next = 1'b1;
                            proc_idx_next   = rd_idx_reg[SB-1:0];
                            rd_idx_next     = rd_idx_reg + 1'b1;
                        end
                        else
                        begin
                            proc_valid_next = 1'b0;
                            state_next      = stt_pkg::S_DONE;
                        end
                    end
                end
            end

            stt_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_push       = 1'b1;
                    out_res.kind   = pend_kind_reg;
                    out_res.ident  = pend_ident_reg;
                    out_res.status = pend_status_reg;
                    out_res.last   = 1'b1;
                    state_next     = stt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = stt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= stt_pkg::S_IDLE;
            rd_idx_reg       <= '0;
            proc_valid_reg   <= 1'b0;
            proc_idx_reg     <= '0;
            is_tick_reg      <= 1'b0;
            slot_used_reg    <= '0;
            slot_cleared_reg <= '0;
            next_ident_reg   <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_idx_reg       <= rd_idx_next;
            proc_valid_reg   <= proc_valid_next;
            proc_idx_reg     <= proc_idx_next;
            is_tick_reg      <= is_tick_next;
            slot_used_reg    <= slot_used_next;
            slot_cleared_reg <= slot_cleared_next;
            next_ident_reg   <= next_ident_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elapsed_reg     <= elapsed_next;
        target_reg      <= target_next;
        pend_kind_reg   <= pend_kind_next;
        pend_ident_reg  <= pend_ident_next;
        pend_status_reg <= pend_status_next;
    end

    `STT_ASSERT_ALWAYS(a_cleared_implies_used, (slot_cleared_reg & ~slot_used_reg) == '0, "cleared flag set on a free slot")
    `STT_ASSERT_IMPL(a_no_same_entry, ram_we && ram_re, ram_waddr != ram_raddr, "slot memory read and written at the same entry")
    `STT_ASSERT_IMPL(a_walk_bound, state_reg == stt_pkg::S_WALK, rd_idx_reg <= stt_pkg::SLOT_COUNT, "walk index ran past the table")

endmodule

`default_nettype wire
